// File: rtl/pdd_pkg.sv
// shared types, constants and kernel tables of the palette error diffusion ditherer
package pdd_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_PALETTE_DEPTH = 16;
    localparam int POSW              = 27;
    localparam int CW                = 14;

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_DRAIN   = 2'd2;

    localparam logic [2:0] CFG_METHOD   = 3'd0;
    localparam logic [2:0] CFG_STRENGTH = 3'd1;
    localparam logic [2:0] CFG_DEFAULT  = 3'd2;
    localparam logic [2:0] CFG_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_HEIGHT   = 3'd4;
    localparam logic [2:0] CFG_PSIZE    = 3'd5;

    typedef struct packed {
        logic signed [2:0] dx;
        logic [1:0]        dy;
        logic [3:0]        wt;
    } t_tap;

    localparam t_tap TAPS [64] = '{
        // floyd-steinberg
        '{3'sd1, 2'd0, 4'd7}, '{-3'sd1, 2'd1, 4'd3}, '{3'sd0, 2'd1, 4'd5}, '{3'sd1, 2'd1, 4'd1},
        // sierra
        '{3'sd1, 2'd0, 4'd5}, '{3'sd2, 2'd0, 4'd3}, '{-3'sd2, 2'd1, 4'd2}, '{-3'sd1, 2'd1, 4'd4},
        '{3'sd0, 2'd1, 4'd5}, '{3'sd1, 2'd1, 4'd4}, '{3'sd2, 2'd1, 4'd2}, '{-3'sd1, 2'd2, 4'd2},
        '{3'sd0, 2'd2, 4'd3}, '{3'sd1, 2'd2, 4'd2},
        // two-row sierra
        '{3'sd1, 2'd0, 4'd4}, '{3'sd2, 2'd0, 4'd3}, '{-3'sd2, 2'd1, 4'd1}, '{-3'sd1, 2'd1, 4'd2},
        '{3'sd0, 2'd1, 4'd3}, '{3'sd1, 2'd1, 4'd2}, '{3'sd2, 2'd1, 4'd1},
        // jarvis-judice-ninke
        '{3'sd1, 2'd0, 4'd7}, '{3'sd2, 2'd0, 4'd5}, '{-3'sd2, 2'd1, 4'd3}, '{-3'sd1, 2'd1, 4'd5},
        '{3'sd0, 2'd1, 4'd7}, '{3'sd1, 2'd1, 4'd5}, '{3'sd2, 2'd1, 4'd3}, '{-3'sd2, 2'd2, 4'd1},
        '{-3'sd1, 2'd2, 4'd3}, '{3'sd0, 2'd2, 4'd5}, '{3'sd1, 2'd2, 4'd3}, '{3'sd2, 2'd2, 4'd1},
        // stucki
        '{3'sd1, 2'd0, 4'd8}, '{3'sd2, 2'd0, 4'd4}, '{-3'sd2, 2'd1, 4'd2}, '{-3'sd1, 2'd1, 4'd4},
        '{3'sd0, 2'd1, 4'd8}, '{3'sd1, 2'd1, 4'd4}, '{3'sd2, 2'd1, 4'd2}, '{-3'sd2, 2'd2, 4'd1},
        '{-3'sd1, 2'd2, 4'd2}, '{3'sd0, 2'd2, 4'd4}, '{3'sd1, 2'd2, 4'd2}, '{3'sd2, 2'd2, 4'd1},
        // sierra lite
        '{3'sd1, 2'd0, 4'd2}, '{-3'sd1, 2'd1, 4'd1}, '{3'sd0, 2'd1, 4'd1},
        // atkinson
        '{3'sd1, 2'd0, 4'd1}, '{3'sd2, 2'd0, 4'd1}, '{-3'sd1, 2'd1, 4'd1}, '{3'sd0, 2'd1, 4'd1},
        '{3'sd1, 2'd1, 4'd1}, '{3'sd0, 2'd2, 4'd1},
        // burkes
        '{3'sd1, 2'd0, 4'd8}, '{3'sd2, 2'd0, 4'd4}, '{-3'sd2, 2'd1, 4'd2}, '{-3'sd1, 2'd1, 4'd4},
        '{3'sd0, 2'd1, 4'd8}, '{3'sd1, 2'd1, 4'd4}, '{3'sd2, 2'd1, 4'd2},
        '{3'sd0, 2'd0, 4'd0}, '{3'sd0, 2'd0, 4'd0}, '{3'sd0, 2'd0, 4'd0}
    };

    function automatic logic [5:0] kern_first(input logic [3:0] m);
        logic [5:0] f;
        unique case (m)
            4'd2:    f = 6'd4;
            4'd3:    f = 6'd14;
            4'd4:    f = 6'd21;
            4'd5:    f = 6'd33;
            4'd6:    f = 6'd45;
            4'd7:    f = 6'd48;
            4'd8:    f = 6'd54;
            default: f = 6'd0;
        endcase
        return f;
    endfunction

    function automatic logic [3:0] kern_count(input logic [3:0] m);
        logic [3:0] c;
        unique case (m)
            4'd1:    c = 4'd4;
            4'd2:    c = 4'd10;
            4'd3:    c = 4'd7;
            4'd4:    c = 4'd12;
            4'd5:    c = 4'd12;
            4'd6:    c = 4'd3;
            4'd7:    c = 4'd6;
            4'd8:    c = 4'd7;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] kern_div(input logic [3:0] m);
        logic [5:0] d;
        unique case (m)
            4'd1:    d = 6'd16;
            4'd2:    d = 6'd32;
            4'd3:    d = 6'd16;
            4'd4:    d = 6'd48;
            4'd5:    d = 6'd42;
            4'd6:    d = 6'd4;
            4'd7:    d = 6'd8;
            4'd8:    d = 6'd32;
            default: d = 6'd1;
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic pix_wr;
        logic pal_wr;
        logic rd_out;
        logic load_pix;
        logic srch_step;
        logic err_calc;
        logic tap_init;
        logic tap_skip;
        logic tap_mul;
        logic tap_div;
        logic tap_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic drain_ok;
        logic emit_due;
        logic quant;
        logic srch_done;
        logic diffuse;
        logic tap_done;
        logic tap_left;
    } t_sts;

endpackage

// File: rtl/pdd_ctrl.sv
// sequencing state machine of the palette error diffusion ditherer
module pdd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_kind,
    input  logic          i_cfg_we,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pdd_pkg::t_cmd o_cmd,
    input  pdd_pkg::t_sts i_sts
);
    import pdd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_TAP   = 4'd6;
    localparam logic [3:0] S_TW    = 4'd7;
    localparam logic [3:0] S_TDIV  = 4'd8;
    localparam logic [3:0] S_TWR   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_settle;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE) && !r_settle;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_PIXEL: begin
                            if (!i_sts.in_full) begin
                                o_cmd.pix_wr = 1'b1;
                                n_state      = S_CHECK;
                            end
                        end
                        KIND_PALETTE: o_cmd.pal_wr = 1'b1;
                        KIND_DRAIN: begin
                            if (i_sts.drain_ok) n_state = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: n_state = i_sts.emit_due ? S_RD : S_IDLE;
            S_RD: begin
                o_cmd.rd_out = 1'b1;
                n_state      = S_RDW;
            end
            S_RDW: begin
                o_cmd.load_pix = 1'b1;
                n_state        = i_sts.quant ? S_SRCH : S_OUT;
            end
            S_SRCH: begin
                if (i_sts.srch_done) n_state = S_ERR;
                else o_cmd.srch_step = 1'b1;
            end
            S_ERR: begin
                o_cmd.err_calc = 1'b1;
                o_cmd.tap_init = 1'b1;
                n_state        = i_sts.diffuse ? S_TAP : S_OUT;
            end
            S_TAP: begin
                if (i_sts.tap_done) n_state = S_OUT;
                else if (i_sts.tap_left) o_cmd.tap_skip = 1'b1;
                else n_state = S_TW;
            end
            S_TW: begin
                o_cmd.tap_mul = 1'b1;
                n_state       = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.tap_div = 1'b1;
                n_state       = S_TWR;
            end
            S_TWR: begin
                o_cmd.tap_wr = 1'b1;
                n_state      = S_TAP;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_settle    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_settle    <= i_cfg_we;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/pdd_dp.sv
// datapath of the palette error diffusion ditherer: row store, palette, search and diffusion
module pdd_dp #(
    parameter int MAX_WIDTH     = pdd_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_DEPTH = pdd_pkg::DEF_PALETTE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pdd_pkg::t_cmd i_cmd,
    output pdd_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [23:0]   i_cfg_data,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_alpha,
    input  logic [3:0]    i_entry_index,
    input  logic [17:0]   i_entry_limit_sq,
    output logic [7:0]    o_out_red,
    output logic [7:0]    o_out_green,
    output logic [7:0]    o_out_blue,
    output logic [7:0]    o_out_alpha,
    output logic [4:0]    o_chosen_entry,
    output logic          o_was_quantized,
    output logic          o_frame_last
);
    import pdd_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int AW   = $clog2(3 * MAX_WIDTH);
    localparam int PAW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PIW  = $clog2(PALETTE_DEPTH + 1);
    localparam int TXW  = CW + 1;

    // configuration
    logic [3:0]  r_method;
    logic [9:0]  r_strength;
    logic [23:0] r_default;
    logic [10:0] r_width_cfg;
    logic [15:0] r_height_cfg;
    logic [4:0]  r_psize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method     <= 4'd0;
            r_strength   <= 10'd256;
            r_default    <= 24'd0;
            r_width_cfg  <= 11'd1024;
            r_height_cfg <= 16'd768;
            r_psize      <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_METHOD:   r_method     <= i_cfg_data[3:0];
                CFG_STRENGTH: r_strength   <= i_cfg_data[9:0];
                CFG_DEFAULT:  r_default    <= i_cfg_data;
                CFG_WIDTH:    r_width_cfg  <= i_cfg_data[10:0];
                CFG_HEIGHT:   r_height_cfg <= i_cfg_data[15:0];
                CFG_PSIZE:    r_psize      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // frame geometry
    logic [CW-1:0]    w_eff, r_w;
    logic [15:0]      h_eff, r_h;
    logic [CW+15:0]   total_full;
    logic [POSW-1:0]  r_total, r_lim;
    logic [PIW-1:0]   r_npal;

    always_comb begin
        w_eff = CW'(r_width_cfg);
        if (r_width_cfg < 11'd3) w_eff = CW'(3);
        else if (CW'(r_width_cfg) > CW'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
        h_eff      = (r_height_cfg < 16'd3) ? 16'd3 : r_height_cfg;
        total_full = w_eff * h_eff;
    end

    always_ff @(posedge i_clk) begin
        r_w     <= w_eff;
        r_h     <= h_eff;
        r_total <= total_full[POSW-1:0];
        r_lim   <= POSW'({w_eff, 1'b0}) + POSW'(3);
        r_npal  <= (9'(r_psize) > 9'(PALETTE_DEPTH)) ? PIW'(PALETTE_DEPTH) : PIW'(r_psize);
    end

    // positions
    logic [XW-1:0]   r_in_x, r_out_x;
    logic [1:0]      r_in_ym3, r_out_ym3;
    logic [15:0]     r_out_y;
    logic [POSW-1:0] r_in_cnt, r_out_cnt;
    logic            in_wrap, out_wrap, last_now;

    assign in_wrap  = (CW'(r_in_x) + CW'(1)) == r_w;
    assign out_wrap = (CW'(r_out_x) + CW'(1)) == r_w;
    assign last_now = (r_out_cnt + POSW'(1)) >= r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT))) begin
            r_in_x    <= '0;
            r_in_ym3  <= 2'd0;
            r_in_cnt  <= '0;
            r_out_x   <= '0;
            r_out_ym3 <= 2'd0;
            r_out_y   <= 16'd0;
            r_out_cnt <= '0;
        end else if (i_cmd.pix_wr) begin
            r_in_cnt <= r_in_cnt + POSW'(1);
            if (in_wrap) begin
                r_in_x   <= '0;
                r_in_ym3 <= (r_in_ym3 == 2'd2) ? 2'd0 : r_in_ym3 + 2'd1;
            end else begin
                r_in_x <= r_in_x + XW'(1);
            end
        end else if (i_cmd.out_load) begin
            if (last_now) begin
                r_in_x    <= '0;
                r_in_ym3  <= 2'd0;
                r_in_cnt  <= '0;
                r_out_x   <= '0;
                r_out_ym3 <= 2'd0;
                r_out_y   <= 16'd0;
                r_out_cnt <= '0;
            end else begin
                r_out_cnt <= r_out_cnt + POSW'(1);
                if (out_wrap) begin
                    r_out_x   <= '0;
                    r_out_y   <= r_out_y + 16'd1;
                    r_out_ym3 <= (r_out_ym3 == 2'd2) ? 2'd0 : r_out_ym3 + 2'd1;
                end else begin
                    r_out_x <= r_out_x + XW'(1);
                end
            end
        end
    end

    function automatic logic [AW-1:0] row_base(input logic [1:0] ym3);
        logic [AW-1:0] b;
        case (ym3)
            2'd0:    b = '0;
            2'd1:    b = AW'(MAX_WIDTH);
            default: b = AW'(2 * MAX_WIDTH);
        endcase
        return b;
    endfunction

    // kernel tap in use
    t_tap                  tap;
    logic [3:0]            r_k;
    logic signed [TXW-1:0] tx;
    logic [2:0]            ty_sum;
    logic [1:0]            ty3;
    logic [AW-1:0]         in_addr, out_addr, tap_addr, r_taddr;
    logic [12:0]           half;
    logic [5:0]            dv;

    always_comb begin
        tap      = TAPS[kern_first(r_method) + 6'(r_k)];
        tx       = $signed({1'b0, CW'(r_out_x)}) + TXW'(tap.dx);
        ty_sum   = {1'b0, r_out_ym3} + {1'b0, tap.dy};
        ty3      = (ty_sum >= 3'd3) ? 2'(ty_sum - 3'd3) : ty_sum[1:0];
        tap_addr = row_base(ty3) + AW'(tx[XW-1:0]);
        in_addr  = row_base(r_in_ym3) + AW'(r_in_x);
        out_addr = row_base(r_out_ym3) + AW'(r_out_x);
        dv       = kern_div(r_method);
        half     = {dv, 7'd0};
    end

    // row store
    logic [31:0]   r_row_store [3 * MAX_WIDTH];
    logic [31:0]   r_rdata, wdata, tap_word;
    logic [AW-1:0] waddr, raddr;
    logic          we;

    assign we    = i_cmd.pix_wr || i_cmd.tap_wr;
    assign waddr = i_cmd.pix_wr ? in_addr : r_taddr;
    assign wdata = i_cmd.pix_wr ? {i_red, i_green, i_blue, i_alpha} : tap_word;
    assign raddr = i_cmd.rd_out ? out_addr : tap_addr;

    always_ff @(posedge i_clk) begin
        if (we) r_row_store[waddr] <= wdata;
        r_rdata <= r_row_store[raddr];
    end

    // palette
    logic [23:0] r_pal_col [PALETTE_DEPTH];
    logic [17:0] r_pal_lim [PALETTE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr && (9'(i_entry_index) < 9'(PALETTE_DEPTH))) begin
            r_pal_col[PAW'(i_entry_index)] <= {i_red, i_green, i_blue};
            r_pal_lim[PAW'(i_entry_index)] <= i_entry_limit_sq;
        end
    end

    // search
    logic [31:0]        r_pix;
    logic               r_quant, quant_now;
    logic [PIW-1:0]     r_si, r_best_idx;
    logic [18:0]        r_best_d;
    logic [23:0]        r_best_col, pal_c;
    logic [17:0]        pal_l, sq_dist;
    logic signed [8:0]  dr [3];
    logic signed [17:0] sq [3];
    logic               hit;

    assign quant_now = (r_rdata[7:0] != 8'd0) && ((CW'(r_out_x) + CW'(2)) < r_w)
                       && (({1'b0, r_out_y} + 17'd2) < {1'b0, r_h});

    always_comb begin
        pal_c = r_pal_col[r_si[PAW-1:0]];
        pal_l = r_pal_lim[r_si[PAW-1:0]];
        for (int ch = 0; ch < 3; ch++) begin
            dr[ch] = $signed({1'b0, r_pix[31-8*ch -: 8]}) - $signed({1'b0, pal_c[23-8*ch -: 8]});
            sq[ch] = dr[ch] * dr[ch];
        end
        sq_dist = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
        hit     = (sq_dist <= pal_l) && ({1'b0, sq_dist} <= r_best_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_pix      <= r_rdata;
            r_quant    <= quant_now;
            r_si       <= '0;
            r_best_d   <= '1;
            r_best_idx <= PIW'(PALETTE_DEPTH);
            r_best_col <= r_default;
        end else if (i_cmd.srch_step) begin
            r_si <= r_si + PIW'(1);
            if (hit) begin
                r_best_d   <= {1'b0, sq_dist};
                r_best_idx <= r_si;
                r_best_col <= pal_c;
            end
        end
    end

    // error and diffusion
    logic signed [19:0] r_es [3];
    logic signed [8:0]  err [3];
    logic signed [24:0] addw [3];
    logic signed [24:0] tsum [3];
    logic signed [15:0] r_m [3];
    logic signed [15:0] sdiv [3];
    logic signed [13:0] r_q [3];
    logic [27:0]        r_p [3];
    logic signed [13:0] qv [3];
    logic signed [13:0] nv [3];
    logic [7:0]         nch [3];
    logic [31:0]        r_nb;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            err[ch]  = $signed({1'b0, r_pix[31-8*ch -: 8]})
                       - $signed({1'b0, r_best_col[23-8*ch -: 8]});
            addw[ch] = r_es[ch] * $signed({1'b0, tap.wt});
            tsum[ch] = addw[ch] + $signed({12'd0, half});
            if (dv == 6'd48) sdiv[ch] = (r_m[ch] >>> 4) + 16'sd768;
            else sdiv[ch] = (r_m[ch] >>> 1) + 16'sd5376;
            case (dv)
                6'd48:   qv[ch] = $signed(14'(r_p[ch] >> 11)) - 14'sd256;
                6'd42:   qv[ch] = $signed(14'(r_p[ch] >> 18)) - 14'sd256;
                default: qv[ch] = r_q[ch];
            endcase
            nv[ch] = $signed({6'd0, r_nb[31-8*ch -: 8]}) + qv[ch];
            if (nv[ch] < 0) nch[ch] = 8'd0;
            else if (nv[ch] > 14'sd255) nch[ch] = 8'd255;
            else nch[ch] = nv[ch][7:0];
        end
        tap_word = {nch[0], nch[1], nch[2], r_nb[7:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_calc) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_es[ch] <= err[ch] * $signed({1'b0, r_strength});
            end
        end
        if (i_cmd.tap_mul) begin
            r_nb <= r_rdata;
            for (int ch = 0; ch < 3; ch++) begin
                r_m[ch] <= 16'(tsum[ch] >>> 8);
            end
        end
        if (i_cmd.tap_div) begin
            for (int ch = 0; ch < 3; ch++) begin
                case (dv)
                    6'd4:    r_q[ch] <= 14'(r_m[ch] >>> 2);
                    6'd8:    r_q[ch] <= 14'(r_m[ch] >>> 3);
                    6'd16:   r_q[ch] <= 14'(r_m[ch] >>> 4);
                    default: r_q[ch] <= 14'(r_m[ch] >>> 5);
                endcase
                if (dv == 6'd48) r_p[ch] <= 28'(sdiv[ch][13:0]) * 28'd683;
                else r_p[ch] <= 28'(sdiv[ch][13:0]) * 28'd12484;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 4'd0;
        end else if (i_cmd.tap_init) begin
            r_k <= 4'd0;
        end else if (i_cmd.tap_skip || i_cmd.tap_wr) begin
            r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(i_cmd.tap_mul || i_cmd.tap_div || i_cmd.tap_wr)) r_taddr <= tap_addr;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_frame_last <= last_now;
            if (r_quant) begin
                o_out_red       <= r_best_col[23:16];
                o_out_green     <= r_best_col[15:8];
                o_out_blue      <= r_best_col[7:0];
                o_out_alpha     <= 8'd255;
                o_chosen_entry  <= 5'(r_best_idx);
                o_was_quantized <= 1'b1;
            end else begin
                o_out_red       <= r_pix[31:24];
                o_out_green     <= r_pix[23:16];
                o_out_blue      <= r_pix[15:8];
                o_out_alpha     <= r_pix[7:0];
                o_chosen_entry  <= 5'(PALETTE_DEPTH);
                o_was_quantized <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.in_full   = r_in_cnt >= r_total;
        o_sts.drain_ok  = (r_in_cnt == r_total) && (r_out_cnt < r_in_cnt);
        o_sts.emit_due  = (r_in_cnt - r_out_cnt) >= r_lim;
        o_sts.quant     = quant_now;
        o_sts.srch_done = r_si >= r_npal;
        o_sts.diffuse   = kern_count(r_method) != 4'd0;
        o_sts.tap_done  = r_k == kern_count(r_method);
        o_sts.tap_left  = tx < 0;
    end

endmodule

// File: rtl/palette_error_diffusion_dither.sv
// top level of the palette error diffusion ditherer
//
// input channel (i_in_valid / o_in_ready) carries pixels, palette entry writes
// and drain items; output channel (o_out_valid / i_out_ready) carries finished
// pixels in raster order. a pixel comes out once 2*width+2 later pixels have
// arrived; drain items push out the tail of a frame one pixel each.
// the configuration port writes one register per cycle with no handshake.
// an item that finishes a pixel reads it back from the row store, searches
// the palette entries one per cycle if the pixel is quantized, and then
// diffuses its error over the kernel taps, each a read-modify-write of the
// row store through the tap, multiply, divide and write states.
// reset clears positions and loads register defaults; the row store and the
// palette are not cleared. input is held off in the cycle after reset and
// after each configuration write. a stalled receiver holds the finished pixel
// in the output register; the next item is still taken, and the block waits
// only when it has another pixel ready to hand over.
module palette_error_diffusion_dither #(
    parameter int MAX_WIDTH     = pdd_pkg::DEF_MAX_WIDTH,
    parameter int PALETTE_DEPTH = pdd_pkg::DEF_PALETTE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic [3:0]  i_entry_index,
    input  logic [17:0] i_entry_limit_sq,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic [4:0]  o_chosen_entry,
    output logic        o_was_quantized,
    output logic        o_frame_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import pdd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_cfg_we    (i_cfg_we),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pdd_dp #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_alpha          (i_alpha),
        .i_entry_index    (i_entry_index),
        .i_entry_limit_sq (i_entry_limit_sq),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_out_alpha      (o_out_alpha),
        .o_chosen_entry   (o_chosen_entry),
        .o_was_quantized  (o_was_quantized),
        .o_frame_last     (o_frame_last)
    );

endmodule
